// File: rtl/acw_pkg.sv
package acw_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int FACTOR_BITS    = 17;
  localparam int FACTOR_SHIFT   = 16;
  localparam int MODE_BITS      = 4;
  localparam int OP_BITS        = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int WHOLE_OUT_BITS = 16;
  localparam int IN_SEG_BITS    = 32;

  localparam int DEFAULT_FRACTION_BITS = 16;
  localparam int DEFAULT_SEGMENT_BITS  = 32;

  localparam logic [VALUE_BITS-1:0]     INIT_WINDOW_RST    = 32'h0001_0000;
  localparam logic [VALUE_BITS-1:0]     INIT_THRESHOLD_RST = 32'hFFFF_FFFF;
  localparam logic [VALUE_BITS-1:0]     INCREASE_STEP_RST  = 32'h0001_0000;
  localparam logic [FACTOR_BITS-1:0]    DECREASE_FACTOR_RST = 17'h0_8000;
  localparam logic [VALUE_BITS-1:0]     THRESHOLD_FLOOR_RST = 32'h0002_0000;
  localparam logic [MODE_BITS-1:0]      MODE_FLAGS_RST     = 4'h0;
  localparam logic [FACTOR_BITS-1:0]    FACTOR_ONE         = 17'h1_0000;
  localparam logic [VALUE_BITS-1:0]     VALUE_MAX          = 32'hFFFF_FFFF;
  localparam logic [WHOLE_OUT_BITS-1:0] WHOLE_MAX          = 16'hFFFF;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_INIT_WINDOW     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INIT_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INCREASE_STEP   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECREASE_FACTOR = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_FLOOR = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE_FLAGS      = 3'd5;

  // mode flag bit positions
  localparam int MODE_CONST_WINDOW  = 0;
  localparam int MODE_NO_GUARD      = 1;
  localparam int MODE_RESET_INITIAL = 2;
  localparam int MODE_IGNORE_MARKS  = 3;

  // event kinds
  localparam logic [OP_BITS-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_BITS-1:0] OP_RECEIVE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_LOSS    = 2'd2;

  typedef struct packed {
    logic load_req;
    logic load_recv;
    logic add_step;
    logic div_start;
    logic add_quot;
    logic set_recov;
    logic mul;
    logic apply_dec;
    logic post;
    logic dec;
  } acw_cmd_t;

  typedef struct packed {
    logic                 win_lt_thr;
    logic                 recv_gt_recov;
    logic                 div_busy;
    logic [MODE_BITS-1:0] mode;
  } acw_status_t;

endpackage

// File: rtl/acw_divider.sv
module acw_divider #(
  parameter int DIVISOR_BITS = acw_pkg::VALUE_BITS - acw_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [acw_pkg::VALUE_BITS-1:0]   dividend_i,
  input  logic [DIVISOR_BITS-1:0]          divisor_i,
  output logic                             busy_o,
  output logic [acw_pkg::VALUE_BITS-1:0]   quotient_o
);
  import acw_pkg::*;

  localparam int CntBits = $clog2(VALUE_BITS + 1);

  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0]   quo_q, quo_d;
  logic [DIVISOR_BITS-1:0] rem_q, rem_d;
  logic [DIVISOR_BITS:0]   rem_shift;
  logic [DIVISOR_BITS:0]   trial;
  logic                    fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_shift = {rem_q, quo_q[VALUE_BITS-1]};
    trial     = rem_shift - {1'b0, divisor_i};
    fits      = rem_shift >= {1'b0, divisor_i};
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    if (start_i) begin
      cnt_d = CntBits'(VALUE_BITS);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      rem_d = fits ? trial[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("divider not busy after start");

endmodule

// File: rtl/acw_datapath.sv
module acw_datapath #(
  parameter int FRACTION_BITS = acw_pkg::DEFAULT_FRACTION_BITS,
  parameter int SEGMENT_BITS  = acw_pkg::DEFAULT_SEGMENT_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_write_i,
  input  logic [acw_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [acw_pkg::VALUE_BITS-1:0]       cfg_data_i,
  input  logic [acw_pkg::IN_SEG_BITS-1:0]      segment_number_i,
  input  acw_pkg::acw_cmd_t                    cmd_i,
  output acw_pkg::acw_status_t                 status_o,
  output logic [acw_pkg::VALUE_BITS-1:0]       window_value_o,
  output logic [acw_pkg::WHOLE_OUT_BITS-1:0]   window_whole_o,
  output logic [acw_pkg::VALUE_BITS-1:0]       threshold_value_o,
  output logic                                 decreased_o
);
  import acw_pkg::*;

  localparam int DivBits  = VALUE_BITS - FRACTION_BITS;
  localparam int WideBits = (SEGMENT_BITS > IN_SEG_BITS) ? SEGMENT_BITS : IN_SEG_BITS;
  localparam int ProdBits = VALUE_BITS + FACTOR_BITS;

  // configuration registers
  logic [VALUE_BITS-1:0]  init_window_q, init_thr_q, step_q, floor_q;
  logic [FACTOR_BITS-1:0] factor_q;
  logic [MODE_BITS-1:0]   mode_q;

  // state
  logic [VALUE_BITS-1:0]   window_q, window_d;
  logic [VALUE_BITS-1:0]   threshold_q, threshold_d;
  logic [SEGMENT_BITS-1:0] recov_q, recv_q, req_q;
  logic [VALUE_BITS:0]     prod_q;

  // result word
  logic [VALUE_BITS-1:0]     out_window_q, out_thr_q;
  logic [WHOLE_OUT_BITS-1:0] out_whole_q;
  logic                      out_dec_q;

  logic [WideBits-1:0]     seg_wide;
  logic [SEGMENT_BITS-1:0] seg;
  logic [DivBits-1:0]      whole, divisor;
  logic [VALUE_BITS-1:0]   whole_ext;
  logic [WHOLE_OUT_BITS-1:0] whole_sat;
  logic [VALUE_BITS-1:0]   addend;
  logic [VALUE_BITS:0]     sum;
  logic [VALUE_BITS-1:0]   sum_sat;
  logic [FACTOR_BITS-1:0]  factor_clamped;
  logic [ProdBits-1:0]     prod_full;
  logic [VALUE_BITS-1:0]   thr_new;
  logic [VALUE_BITS-1:0]   quotient;

  assign seg_wide = WideBits'(segment_number_i);
  assign seg      = seg_wide[SEGMENT_BITS-1:0];

  assign whole     = window_q[VALUE_BITS-1:FRACTION_BITS];
  assign divisor   = (whole == '0) ? DivBits'(1) : whole;
  assign whole_ext = VALUE_BITS'(whole);
  assign whole_sat = (whole_ext > VALUE_BITS'(WHOLE_MAX)) ? WHOLE_MAX
                                                          : whole_ext[WHOLE_OUT_BITS-1:0];

  acw_divider #(
    .DIVISOR_BITS(DivBits)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (step_q),
    .divisor_i  (divisor),
    .busy_o     (status_o.div_busy),
    .quotient_o (quotient)
  );

  // saturating add of the step or the divided step
  assign addend  = cmd_i.add_quot ? quotient : step_q;
  assign sum     = {1'b0, window_q} + {1'b0, addend};
  assign sum_sat = sum[VALUE_BITS] ? VALUE_MAX : sum[VALUE_BITS-1:0];

  assign factor_clamped = (factor_q > FACTOR_ONE) ? FACTOR_ONE : factor_q;
  assign prod_full      = {{FACTOR_BITS{1'b0}}, window_q} * {{VALUE_BITS{1'b0}}, factor_clamped};
  assign thr_new        = (prod_q > {1'b0, floor_q}) ? prod_q[VALUE_BITS-1:0] : floor_q;

  always_comb begin
    window_d    = window_q;
    threshold_d = threshold_q;
    if (cmd_i.add_step || cmd_i.add_quot) begin
      window_d = sum_sat;
    end else if (cmd_i.apply_dec) begin
      threshold_d = thr_new;
      window_d    = mode_q[MODE_RESET_INITIAL] ? init_window_q : thr_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_window_q <= INIT_WINDOW_RST;
      init_thr_q    <= INIT_THRESHOLD_RST;
      step_q        <= INCREASE_STEP_RST;
      factor_q      <= DECREASE_FACTOR_RST;
      floor_q       <= THRESHOLD_FLOOR_RST;
      mode_q        <= MODE_FLAGS_RST;
      window_q      <= INIT_WINDOW_RST;
      threshold_q   <= INIT_THRESHOLD_RST;
      recov_q       <= '0;
      recv_q        <= '0;
      req_q         <= '0;
    end else begin
      if (cfg_write_i) begin
        case (cfg_index_i)
          REG_INIT_WINDOW:     init_window_q <= cfg_data_i;
          REG_INIT_THRESHOLD:  init_thr_q    <= cfg_data_i;
          REG_INCREASE_STEP:   step_q        <= cfg_data_i;
          REG_DECREASE_FACTOR: factor_q      <= cfg_data_i[FACTOR_BITS-1:0];
          REG_THRESHOLD_FLOOR: floor_q       <= cfg_data_i;
          REG_MODE_FLAGS:      mode_q        <= cfg_data_i[MODE_BITS-1:0];
          default: ;
        endcase
      end
      window_q    <= window_d;
      threshold_q <= threshold_d;
      if (cmd_i.load_req) begin
        req_q <= seg;
      end
      if (cmd_i.load_recv && (seg > recv_q)) begin
        recv_q <= seg;
      end
      if (cmd_i.set_recov) begin
        recov_q <= req_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_full[ProdBits-1:FACTOR_SHIFT];
    end
    if (cmd_i.post) begin
      out_window_q <= window_q;
      out_whole_q  <= whole_sat;
      out_thr_q    <= threshold_q;
      out_dec_q    <= cmd_i.dec;
    end
  end

  assign status_o.win_lt_thr    = window_q < threshold_q;
  assign status_o.recv_gt_recov = recv_q > recov_q;
  assign status_o.mode          = mode_q;

  assign window_value_o    = out_window_q;
  assign window_whole_o    = out_whole_q;
  assign threshold_value_o = out_thr_q;
  assign decreased_o       = out_dec_q;

  a_thr_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply_dec |=> threshold_q >= floor_q)
    else $error("threshold below floor after decrease");

endmodule

// File: rtl/acw_ctrl.sv
module acw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [acw_pkg::OP_BITS-1:0]   op_i,
  input  logic                          congestion_marked_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  acw_pkg::acw_status_t          status_i,
  output acw_pkg::acw_cmd_t             cmd_o
);
  import acw_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_POST   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [OP_BITS-1:0] op_q, op_d;
  logic               mark_q, mark_d;
  logic               dec_q, dec_d;
  logic               out_valid_q, out_valid_d;
  logic               accept;
  logic               mark_acts;
  logic               do_shrink;
  logic               do_grow;
  logic               guard_ok;
  logic               const_win;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign mark_acts = mark_q && !status_i.mode[MODE_IGNORE_MARKS];
  assign do_shrink = (op_q == OP_LOSS) || ((op_q == OP_RECEIVE) && mark_acts);
  assign do_grow   = (op_q == OP_RECEIVE) && !mark_acts;
  assign guard_ok  = status_i.mode[MODE_NO_GUARD] || status_i.recv_gt_recov;
  assign const_win = status_i.mode[MODE_CONST_WINDOW];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    mark_d      = mark_q;
    dec_d       = dec_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.dec   = dec_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_req  = op_i == OP_REQUEST;
          cmd_o.load_recv = op_i == OP_RECEIVE;
          op_d            = op_i;
          mark_d          = congestion_marked_i;
          dec_d           = 1'b0;
          state_d         = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_POST;
        if (do_shrink) begin
          if (guard_ok) begin
            cmd_o.set_recov = 1'b1;
            if (!const_win) begin
              cmd_o.mul = 1'b1;
              state_d   = S_MUL;
            end
          end
        end else if (do_grow && !const_win) begin
          if (status_i.win_lt_thr) begin
            cmd_o.add_step = 1'b1;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.add_quot = 1'b1;
          state_d        = S_POST;
        end
      end
      S_MUL: begin
        cmd_o.apply_dec = 1'b1;
        dec_d           = 1'b1;
        state_d         = S_POST;
      end
      S_POST: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.post  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dec_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dec_q       <= dec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    mark_q <= mark_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_DECIDE)
    else $error("accepted word did not move to decide");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !status_i.div_busy) |=> state_q == S_POST)
    else $error("division finished without posting");

  a_post_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_POST)
    else $error("result valid raised outside post");

endmodule

// File: rtl/aimd_congestion_window_core.sv
// Channel   Direction  Handshake              Word
// -------   ---------  ---------------------  ------------------------------------------
// in        input      in_valid_i/in_stall_o   op, segment_number, congestion_marked
// out       output     out_valid_o/out_stall_i window_value, window_whole, threshold_value,
//                                             decreased
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An event word passes through decide and post (request, loss without decrease, growth
// below the threshold), a multiplicative decrease adds a multiply step, and growth at or
// above the threshold adds a wait on the serial divider, which makes one quotient bit per cycle.
// One word is in work at a time; the next one is taken once the result is in the
// output register. A stalled output holds the finished word and delays only the next.
// Reset loads the default registers and window/threshold; cfg is always ready.
module aimd_congestion_window_core #(
  parameter int FRACTION_BITS = acw_pkg::DEFAULT_FRACTION_BITS,
  parameter int SEGMENT_BITS  = acw_pkg::DEFAULT_SEGMENT_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [acw_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [acw_pkg::VALUE_BITS-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [acw_pkg::OP_BITS-1:0]          op_i,
  input  logic [acw_pkg::IN_SEG_BITS-1:0]      segment_number_i,
  input  logic                                 congestion_marked_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [acw_pkg::VALUE_BITS-1:0]       window_value_o,
  output logic [acw_pkg::WHOLE_OUT_BITS-1:0]   window_whole_o,
  output logic [acw_pkg::VALUE_BITS-1:0]       threshold_value_o,
  output logic                                 decreased_o
);
  import acw_pkg::*;

  acw_cmd_t    cmd;
  acw_status_t status;

  assign cfg_ready_o = 1'b1;

  acw_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .op_i                (op_i),
    .congestion_marked_i (congestion_marked_i),
    .in_stall_o          (in_stall_o),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_i            (status),
    .cmd_o               (cmd)
  );

  acw_datapath #(
    .FRACTION_BITS(FRACTION_BITS),
    .SEGMENT_BITS (SEGMENT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_write_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .segment_number_i  (segment_number_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .window_value_o    (window_value_o),
    .window_whole_o    (window_whole_o),
    .threshold_value_o (threshold_value_o),
    .decreased_o       (decreased_o)
  );

endmodule

// File: tb/sv/aimd_window_checker.sv
module aimd_window_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [acw_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [acw_pkg::VALUE_BITS-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [acw_pkg::OP_BITS-1:0]        op_i,
  input  logic [acw_pkg::IN_SEG_BITS-1:0]    segment_number_i,
  input  logic                               congestion_marked_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [acw_pkg::VALUE_BITS-1:0]     window_value_i,
  input  logic [acw_pkg::WHOLE_OUT_BITS-1:0] window_whole_i,
  input  logic [acw_pkg::VALUE_BITS-1:0]     threshold_value_i,
  input  logic                               decreased_i,
  output int                                 mismatches_o,
  output int                                 pending_o,
  output int                                 results_o,
  output int                                 decreases_o,
  output int                                 avoidance_o
);
  import acw_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0]     window;
    logic [WHOLE_OUT_BITS-1:0] whole;
    logic [VALUE_BITS-1:0]     threshold;
    logic                      decreased;
  } window_report_t;

  window_report_t expected_reports[$];
  window_report_t head;

  logic [VALUE_BITS-1:0]  cfg_init_window;
  logic [VALUE_BITS-1:0]  cfg_init_threshold;
  logic [VALUE_BITS-1:0]  cfg_step;
  logic [FACTOR_BITS-1:0] cfg_factor;
  logic [VALUE_BITS-1:0]  cfg_floor;
  logic [MODE_BITS-1:0]   cfg_mode;

  logic [VALUE_BITS-1:0]  cwnd;
  logic [VALUE_BITS-1:0]  ssthresh;
  logic [IN_SEG_BITS-1:0] recover_seg;
  logic [IN_SEG_BITS-1:0] top_received;
  logic [IN_SEG_BITS-1:0] top_requested;

  function automatic logic [VALUE_BITS-1:0] add_saturating(logic [VALUE_BITS-1:0] a,
                                                           logic [VALUE_BITS-1:0] b);
    logic [VALUE_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[VALUE_BITS] ? VALUE_MAX : sum[VALUE_BITS-1:0];
  endfunction

  task automatic grow_window();
    logic [VALUE_BITS-1:0] segs;
    if (cfg_mode[MODE_CONST_WINDOW]) return;
    if (cwnd < ssthresh) begin
      cwnd = add_saturating(cwnd, cfg_step);
    end else begin
      // a window below one segment divides by one
      segs = cwnd >> DEFAULT_FRACTION_BITS;
      if (segs == 0) segs = 1;
      cwnd = add_saturating(cwnd, cfg_step / segs);
      avoidance_o++;
    end
  endtask

  task automatic shrink_window(output logic cut);
    logic [FACTOR_BITS-1:0]            factor;
    logic [VALUE_BITS+FACTOR_BITS-1:0] prod;
    cut = 1'b0;
    if (!(cfg_mode[MODE_NO_GUARD] || top_received > recover_seg)) return;
    recover_seg = top_requested;
    if (cfg_mode[MODE_CONST_WINDOW]) return;
    factor = (cfg_factor > FACTOR_ONE) ? FACTOR_ONE : cfg_factor;
    prod = {{FACTOR_BITS{1'b0}}, cwnd};
    prod = (prod * factor) >> FACTOR_SHIFT;
    ssthresh = (prod > cfg_floor) ? prod[VALUE_BITS-1:0] : cfg_floor;
    cwnd = cfg_mode[MODE_RESET_INITIAL] ? cfg_init_window : ssthresh;
    cut = 1'b1;
  endtask

  task automatic predict_event(logic [OP_BITS-1:0] op, logic [IN_SEG_BITS-1:0] seg,
                               logic marked);
    window_report_t rpt;
    logic cut;
    logic [VALUE_BITS-1:0] segs;
    cut = 1'b0;
    case (op)
      OP_REQUEST: top_requested = seg;
      OP_RECEIVE: begin
        if (seg > top_received) top_received = seg;
        if (marked && !cfg_mode[MODE_IGNORE_MARKS]) shrink_window(cut);
        else grow_window();
      end
      OP_LOSS: shrink_window(cut);
      default: ;
    endcase
    segs = cwnd >> DEFAULT_FRACTION_BITS;
    rpt.window    = cwnd;
    rpt.whole     = (segs > WHOLE_MAX) ? WHOLE_MAX : segs[WHOLE_OUT_BITS-1:0];
    rpt.threshold = ssthresh;
    rpt.decreased = cut;
    expected_reports.push_back(rpt);
  endtask

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (got === want) return 0;
    $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_init_window    = INIT_WINDOW_RST;
      cfg_init_threshold = INIT_THRESHOLD_RST;
      cfg_step           = INCREASE_STEP_RST;
      cfg_factor         = DECREASE_FACTOR_RST;
      cfg_floor          = THRESHOLD_FLOOR_RST;
      cfg_mode           = MODE_FLAGS_RST;
      cwnd               = INIT_WINDOW_RST;
      ssthresh           = INIT_THRESHOLD_RST;
      recover_seg        = '0;
      top_received       = '0;
      top_requested      = '0;
      expected_reports.delete();
      mismatches_o       = 0;
      results_o          = 0;
      decreases_o        = 0;
      avoidance_o        = 0;
      pending_o          = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_INIT_WINDOW:     cfg_init_window    = cfg_data_i;
          REG_INIT_THRESHOLD:  cfg_init_threshold = cfg_data_i;
          REG_INCREASE_STEP:   cfg_step           = cfg_data_i;
          REG_DECREASE_FACTOR: cfg_factor         = cfg_data_i[FACTOR_BITS-1:0];
          REG_THRESHOLD_FLOOR: cfg_floor          = cfg_data_i;
          REG_MODE_FLAGS:      cfg_mode           = cfg_data_i[MODE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_event(op_i, segment_number_i, congestion_marked_i);
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_reports.size() == 0) begin
          $display("%0t: result word with nothing expected: window %0h threshold %0h",
                   $time, window_value_i, threshold_value_i);
          mismatches_o++;
        end else begin
          head = expected_reports.pop_front();
          mismatches_o += field_differs("window_value", head.window, window_value_i)
                        + field_differs("window_whole", 32'(head.whole),
                                        32'(window_whole_i))
                        + field_differs("threshold_value", head.threshold, threshold_value_i)
                        + field_differs("decreased", 32'(head.decreased), 32'(decreased_i));
          if (head.decreased) decreases_o++;
        end
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

// File: tb/sv/aimd_congestion_window_core_test.sv
module aimd_congestion_window_core_test;
  import acw_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 9;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int TAIL_CYCLES   = 40;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_WORDS   = 100;
  localparam int GAP_PERCENT   = 15;

  localparam logic [OP_BITS-1:0]        OP_UNUSED    = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [VALUE_BITS-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OP_BITS-1:0]        op = OP_REQUEST;
  logic [IN_SEG_BITS-1:0]    segment_number = '0;
  logic                      congestion_marked = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [VALUE_BITS-1:0]     window_value;
  logic [WHOLE_OUT_BITS-1:0] window_whole;
  logic [VALUE_BITS-1:0]     threshold_value;
  logic                      decreased;

  int  mismatches;
  int  pending;
  int  results;
  int  decreases;
  int  avoidance_steps;
  int  settings_used = 0;
  int  quiet_cycles = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  logic [IN_SEG_BITS-1:0] seg_cursor;
  logic [IN_SEG_BITS-1:0] ack_cursor;

  aimd_congestion_window_core dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .op_i                (op),
    .segment_number_i    (segment_number),
    .congestion_marked_i (congestion_marked),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .window_value_o      (window_value),
    .window_whole_o      (window_whole),
    .threshold_value_o   (threshold_value),
    .decreased_o         (decreased)
  );

  aimd_window_checker window_check (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .op_i                (op),
    .segment_number_i    (segment_number),
    .congestion_marked_i (congestion_marked),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .window_value_i      (window_value),
    .window_whole_i      (window_whole),
    .threshold_value_i   (threshold_value),
    .decreased_i         (decreased),
    .mismatches_o        (mismatches),
    .pending_o           (pending),
    .results_o           (results),
    .decreases_o         (decreases),
    .avoidance_o         (avoidance_steps)
  );

  always #HALF_PERIOD clk = ~clk;

  // receiver: random stalls, or one long hold when asked
  always begin
    @(negedge clk);
    if (hold_req && !hold_done) begin
      for (int n = 0; n < HOLD_CYCLES; n++) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end
      hold_done = 1'b1;
    end else begin
      out_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(logic [OP_BITS-1:0] kind, logic [IN_SEG_BITS-1:0] seg,
                           logic marked);
    while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    op                <= kind;
    segment_number    <= seg;
    congestion_marked <= marked;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [VALUE_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(logic [31:0] init_win, logic [31:0] init_thr, logic [31:0] step,
                           logic [31:0] factor, logic [31:0] floor_val, logic [31:0] mode);
    write_reg(REG_INIT_WINDOW, init_win);
    write_reg(REG_INIT_THRESHOLD, init_thr);
    write_reg(REG_INCREASE_STEP, step);
    write_reg(REG_DECREASE_FACTOR, factor);
    write_reg(REG_THRESHOLD_FLOOR, floor_val);
    write_reg(REG_MODE_FLAGS, mode);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    cfg_valid <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return VALUE_MAX;
      2:       return $urandom();
      3:       return $urandom_range(0, 32'h0010_0000);
      4:       return 32'h0001_0000 * $urandom_range(1, 64);
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_window();
    case ($urandom_range(0, 3))
      0:       return INIT_WINDOW_RST;
      1:       return VALUE_MAX;
      2:       return $urandom_range(32'h0001_0000, VALUE_MAX);
      default: return $urandom_range(32'h0001_0000, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_factor();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'(FACTOR_ONE);
      2:       return 32'(DECREASE_FACTOR_RST);
      3:       return $urandom_range(0, FACTOR_ONE);
      4:       return $urandom();
      default: return $urandom_range(FACTOR_ONE + 1, 32'h0001_FFFF);
    endcase
  endfunction

  // mostly in-order request/receive traffic with marks and losses, some noise
  task automatic random_event();
    int pick;
    logic [OP_BITS-1:0] kind;
    pick = $urandom_range(0, 99);
    if (pick < 40 || (pick < 80 && ack_cursor == seg_cursor)) begin
      send_word(OP_REQUEST, seg_cursor, 1'($urandom_range(0, 1)));
      seg_cursor++;
    end else if (pick < 80) begin
      send_word(OP_RECEIVE, ack_cursor, $urandom_range(0, 99) < 6);
      ack_cursor++;
    end else if (pick < 88) begin
      send_word(OP_LOSS, $urandom(), 1'($urandom_range(0, 1)));
    end else begin
      kind = OP_BITS'($urandom_range(0, 3));
      send_word(kind, $urandom_range(ack_cursor, seg_cursor + 64),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: guard on, infinite threshold
    send_word(OP_UNUSED, '1, 1'b1);
    send_word(OP_REQUEST, '1, 1'b1);
    send_word(OP_REQUEST, '0, 1'b0);
    send_word(OP_RECEIVE, '0, 1'b0);
    send_word(OP_LOSS, '1, 1'b0);
    send_word(OP_REQUEST, 32'd4, 1'b0);
    send_word(OP_RECEIVE, 32'd1, 1'b0);
    send_word(OP_RECEIVE, 32'd2, 1'b1);
    send_word(OP_LOSS, '0, 1'b0);
    send_word(OP_RECEIVE, 32'd3, 1'b0);
    wait_drained();

    // reset to a full initial window, then saturate in avoidance
    configure(VALUE_MAX, '0, VALUE_MAX, '0, '0,
              (1 << MODE_NO_GUARD) | (1 << MODE_RESET_INITIAL));
    send_word(OP_LOSS, 32'd0, 1'b0);
    send_word(OP_RECEIVE, 32'd5, 1'b0);
    wait_drained();

    // window drops below one segment, then grows by the whole step
    configure(INIT_WINDOW_RST, VALUE_MAX, 32'h0001_8000, '0, '0, 1 << MODE_NO_GUARD);
    send_word(OP_LOSS, 32'd0, 1'b0);
    send_word(OP_RECEIVE, 32'd6, 1'b0);
    send_word(OP_RECEIVE, 32'd7, 1'b0);
    wait_drained();

    // factor above one clamps; marks ignored
    configure(INIT_WINDOW_RST, '0, INCREASE_STEP_RST, 32'h0001_FFFF, '0,
              (1 << MODE_NO_GUARD) | (1 << MODE_IGNORE_MARKS));
    send_word(OP_RECEIVE, 32'd8, 1'b1);
    send_word(OP_LOSS, 32'd0, 1'b0);
    wait_drained();

    // frozen window; recovery point still advances
    configure(INIT_WINDOW_RST, VALUE_MAX, INCREASE_STEP_RST, 32'(DECREASE_FACTOR_RST),
              THRESHOLD_FLOOR_RST, 1 << MODE_CONST_WINDOW);
    send_word(OP_REQUEST, 32'd20, 1'b0);
    send_word(OP_RECEIVE, 32'd9, 1'b0);
    send_word(OP_LOSS, 32'd0, 1'b0);
    send_word(OP_RECEIVE, 32'd10, 1'b1);
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      configure(pick_window(), pick_value(), pick_value(), pick_factor(), pick_value(),
                $urandom());
      gaps_on = (phase != 3);
      // each phase's request and receive cursors start above those of the earlier phases
      seg_cursor = phase * 32'h1300_0000 + $urandom_range(0, 32'h00FF_FFFF) + 32;
      ack_cursor = seg_cursor;
      if (phase == 5) hold_req = 1'b1;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (phase == 7 && k == PHASE_WORDS / 2) wait_drained();
        random_event();
      end
      wait_drained();
    end
    gaps_on = 1'b1;

    // top segment number: decrease once, then the guard holds
    configure(INIT_WINDOW_RST, INIT_THRESHOLD_RST, INCREASE_STEP_RST,
              32'(DECREASE_FACTOR_RST), THRESHOLD_FLOOR_RST, 32'(MODE_FLAGS_RST));
    send_word(OP_REQUEST, '1, 1'b0);
    send_word(OP_RECEIVE, '1, 1'b0);
    send_word(OP_LOSS, '1, 1'b1);
    send_word(OP_LOSS, '0, 1'b0);
    send_word(OP_RECEIVE, '1, 1'b1);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Checked %0d result words under %0d register settings: %0d decreases, %0d",
             results, settings_used, decreases, avoidance_steps);
    $display("  of them congestion-avoidance steps; one long output hold, one gap-free phase");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
